// ===== design/jcc_pkg.sv =====
// Shared types and constants for the joystick command conditioner.
// Used by jcc_ctrl, jcc_datapath and joystick_command_conditioner; no dependencies.

package jcc_pkg;

  // Multiply schedule: four smoothing products, four deadband products,
  // three step products, then a final step to retire the last product.
  localparam int unsigned StepWidth = 4;
  localparam logic [StepWidth-1:0] SMOOTH_END = 4'd4;
  localparam logic [StepWidth-1:0] BAND_END   = 4'd8;
  localparam logic [StepWidth-1:0] ISSUE_END  = 4'd11;

  localparam int unsigned LaneCount = 4;
  localparam int unsigned StepCount = 3;

  // Lane order follows the result fields
  localparam logic [1:0] LANE_FORWARD = 2'd0;  // left vertical
  localparam logic [1:0] LANE_LATERAL = 2'd1;  // left horizontal, negated
  localparam logic [1:0] LANE_TURN    = 2'd2;  // right horizontal, negated
  localparam logic [1:0] LANE_PITCH   = 2'd3;  // right vertical

  // Configuration register indexes
  localparam logic [2:0] REG_FILTER_GAIN    = 3'd0;
  localparam logic [2:0] REG_DEADBAND_WIDTH = 3'd1;
  localparam logic [2:0] REG_STEP_TIME      = 3'd2;
  localparam logic [2:0] REG_FORWARD_SPAN   = 3'd3;
  localparam logic [2:0] REG_LATERAL_SPAN   = 3'd4;
  localparam logic [2:0] REG_TURN_SPAN      = 3'd5;
  localparam logic [2:0] REG_PITCH_SPAN     = 3'd6;

  localparam logic [15:0] RST_FILTER_GAIN    = 16'd6554;
  localparam logic [14:0] RST_DEADBAND_WIDTH = 15'd3277;
  localparam logic [15:0] RST_STEP_TIME      = 16'd131;
  localparam logic [15:0] RST_SPAN           = 16'd256;

  localparam logic signed [15:0] AXIS_MIN = 16'sh8000;
  localparam logic signed [15:0] AXIS_MAX = 16'sh7fff;

  typedef enum logic [1:0] {
    OP_SMOOTH,
    OP_BAND,
    OP_STEP
  } op_t;

  typedef struct packed {
    logic       load_in;
    logic       issue;
    op_t        op;
    logic [1:0] lane;
    logic       load_out;
  } cmd_t;

endpackage

// ===== design/joystick_command_conditioner.sv =====
// Joystick command conditioner: smoothing, deadband and scaling of four stick axes.
// Top level; instantiates jcc_ctrl and jcc_datapath, uses jcc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one gamepad sample: four Q1.15
//   axes. Output channel (out_valid / out_stall) carries seven Q8.8 commands.
//   A transfer happens on a rising edge with valid high and stall low.
//   The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no sample is in flight. Unknown indexes
//   are dropped.
//   Each sample runs eleven products through one shared 17x17 multiplier,
//   retires the last product and loads the output register; only then does
//   the input side return to idle and take the next sample.
//   The output register frees the input side: a new sample may start while the
//   previous result waits; a stalled result holds, and the finished sample
//   waits for the output register before the next one is taken.
//   Synchronous reset restores default registers and zeroes filter state.

module joystick_command_conditioner (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] left_horizontal,
  input  logic signed [15:0] left_vertical,
  input  logic signed [15:0] right_horizontal,
  input  logic signed [15:0] right_vertical,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] forward_velocity,
  output logic signed [15:0] lateral_velocity,
  output logic signed [15:0] yaw_rate,
  output logic signed [15:0] body_pitch,
  output logic signed [15:0] forward_step,
  output logic signed [15:0] lateral_step,
  output logic signed [15:0] yaw_step,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  jcc_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  jcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  jcc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .left_horizontal  (left_horizontal),
    .left_vertical    (left_vertical),
    .right_horizontal (right_horizontal),
    .right_vertical   (right_vertical),
    .forward_velocity (forward_velocity),
    .lateral_velocity (lateral_velocity),
    .yaw_rate         (yaw_rate),
    .body_pitch       (body_pitch),
    .forward_step     (forward_step),
    .lateral_step     (lateral_step),
    .yaw_step         (yaw_step)
  );

endmodule

// ===== design/jcc_ctrl.sv =====
// Sequencer for the joystick command conditioner: input/output handshake and
// the multiply schedule. Depends on jcc_pkg; drives jcc_datapath through cmd_t.

module jcc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output jcc_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                          state;
  logic [jcc_pkg::StepWidth-1:0]   step;
  logic                            out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = in_valid && (state == S_IDLE);
    cmd.issue    = (state == S_RUN) && (step < jcc_pkg::ISSUE_END);
    cmd.lane     = step[1:0];
    cmd.load_out = (state == S_DONE) && out_free;
    if (step < jcc_pkg::SMOOTH_END) begin
      cmd.op = jcc_pkg::OP_SMOOTH;
    end else if (step < jcc_pkg::BAND_END) begin
      cmd.op = jcc_pkg::OP_BAND;
    end else begin
      cmd.op = jcc_pkg::OP_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          step <= '0;
          if (in_valid) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          // last cycle retires the final product
          if (step == jcc_pkg::ISSUE_END) begin
            state <= S_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_RUN && step == '0))
    else $error("accepted item did not start the schedule");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented without finishing the schedule");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (step <= jcc_pkg::ISSUE_END))
    else $error("schedule counter ran past its end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.load_out)
    else $error("stalled result overwritten");

endmodule

// ===== design/jcc_datapath.sv =====
// Datapath for the joystick command conditioner: config registers, filter state,
// one shared 17x17 multiplier and result registers. Depends on jcc_pkg.

module jcc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  jcc_pkg::cmd_t      cmd,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic signed [15:0] left_horizontal,
  input  logic signed [15:0] left_vertical,
  input  logic signed [15:0] right_horizontal,
  input  logic signed [15:0] right_vertical,
  output logic signed [15:0] forward_velocity,
  output logic signed [15:0] lateral_velocity,
  output logic signed [15:0] yaw_rate,
  output logic signed [15:0] body_pitch,
  output logic signed [15:0] forward_step,
  output logic signed [15:0] lateral_step,
  output logic signed [15:0] yaw_step
);

  logic [15:0] filter_gain;
  logic [14:0] deadband_width;
  logic [15:0] step_time;
  logic [15:0] forward_span;
  logic [15:0] lateral_span;
  logic [15:0] turn_span;
  logic [15:0] pitch_span;

  logic signed [15:0] axis    [jcc_pkg::LaneCount];
  logic signed [15:0] smooth  [jcc_pkg::LaneCount];
  logic signed [15:0] rate    [jcc_pkg::LaneCount];
  logic signed [15:0] incr    [jcc_pkg::StepCount];

  logic signed [15:0] cur_smooth;
  logic signed [15:0] cur_rate;
  logic [15:0]        cur_span;
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [16:0] band_hi;
  logic signed [16:0] band_lo;
  logic               in_band;

  logic signed [33:0] prod;
  logic signed [15:0] base;
  logic               in_band_d;
  logic               valid_d;
  jcc_pkg::op_t       op_d;
  logic [1:0]         lane_d;
  logic signed [15:0] prod_hi;

  function automatic logic signed [15:0] negate_sat(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = (v == jcc_pkg::AXIS_MIN) ? jcc_pkg::AXIS_MAX : -v;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_gain    <= jcc_pkg::RST_FILTER_GAIN;
      deadband_width <= jcc_pkg::RST_DEADBAND_WIDTH;
      step_time      <= jcc_pkg::RST_STEP_TIME;
      forward_span   <= jcc_pkg::RST_SPAN;
      lateral_span   <= jcc_pkg::RST_SPAN;
      turn_span      <= jcc_pkg::RST_SPAN;
      pitch_span     <= jcc_pkg::RST_SPAN;
    end else if (cfg_we) begin
      case (cfg_index)
        jcc_pkg::REG_FILTER_GAIN:    filter_gain    <= cfg_data;
        jcc_pkg::REG_DEADBAND_WIDTH: deadband_width <= cfg_data[14:0];
        jcc_pkg::REG_STEP_TIME:      step_time      <= cfg_data;
        jcc_pkg::REG_FORWARD_SPAN:   forward_span   <= cfg_data;
        jcc_pkg::REG_LATERAL_SPAN:   lateral_span   <= cfg_data;
        jcc_pkg::REG_TURN_SPAN:      turn_span      <= cfg_data;
        jcc_pkg::REG_PITCH_SPAN:     pitch_span     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Capture a sample, horizontal axes negated
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      axis[jcc_pkg::LANE_FORWARD] <= left_vertical;
      axis[jcc_pkg::LANE_LATERAL] <= negate_sat(left_horizontal);
      axis[jcc_pkg::LANE_TURN]    <= negate_sat(right_horizontal);
      axis[jcc_pkg::LANE_PITCH]   <= right_vertical;
    end
  end

  assign cur_smooth = smooth[cmd.lane];
  assign cur_rate   = rate[cmd.lane];

  always_comb begin
    case (cmd.lane)
      jcc_pkg::LANE_FORWARD: cur_span = forward_span;
      jcc_pkg::LANE_LATERAL: cur_span = lateral_span;
      jcc_pkg::LANE_TURN:    cur_span = turn_span;
      default:               cur_span = pitch_span;
    endcase
  end

  assign band_hi = signed'({2'b00, deadband_width});
  assign band_lo = -band_hi;
  assign in_band = (signed'({cur_smooth[15], cur_smooth}) < band_hi) &&
                   (signed'({cur_smooth[15], cur_smooth}) > band_lo);

  // s*(1-g) + x*g is rewritten as s + (x - s)*g
  always_comb begin
    case (cmd.op)
      jcc_pkg::OP_SMOOTH: begin
        mul_a = {axis[cmd.lane][15], axis[cmd.lane]} - {cur_smooth[15], cur_smooth};
        mul_b = signed'({1'b0, filter_gain});
      end
      jcc_pkg::OP_BAND: begin
        mul_a = {cur_smooth[15], cur_smooth};
        mul_b = signed'({1'b0, cur_span});
      end
      default: begin
        mul_a = {cur_rate[15], cur_rate};
        mul_b = signed'({1'b0, step_time});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d <= 1'b0;
    end else begin
      valid_d <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod      <= mul_a * mul_b;
    base      <= cur_smooth;
    in_band_d <= in_band;
    op_d      <= cmd.op;
    lane_d    <= cmd.lane;
  end

  // Floor shift by 16; every result fits in 16 bits
  assign prod_hi = prod[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < jcc_pkg::LaneCount; i++) begin
        smooth[i] <= '0;
      end
    end else if (valid_d && op_d == jcc_pkg::OP_SMOOTH) begin
      smooth[lane_d] <= base + prod_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_d) begin
      case (op_d)
        jcc_pkg::OP_BAND: begin
          rate[lane_d] <= in_band_d ? '0 : prod_hi;
        end
        jcc_pkg::OP_STEP: begin
          case (lane_d)
            jcc_pkg::LANE_FORWARD: incr[0] <= prod_hi;
            jcc_pkg::LANE_LATERAL: incr[1] <= prod_hi;
            jcc_pkg::LANE_TURN:    incr[2] <= prod_hi;
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Hold results here so the next sample can run while these wait
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      forward_velocity <= rate[jcc_pkg::LANE_FORWARD];
      lateral_velocity <= rate[jcc_pkg::LANE_LATERAL];
      yaw_rate         <= rate[jcc_pkg::LANE_TURN];
      body_pitch       <= rate[jcc_pkg::LANE_PITCH];
      forward_step     <= incr[0];
      lateral_step     <= incr[1];
      yaw_step         <= incr[2];
    end
  end

endmodule

// ===== tb/motion_command_checker.sv =====
// Checker for the joystick command conditioner: predicts each command set
// from the accepted samples and register writes, and compares the results.
// Depends on jcc_pkg for register indexes, reset values and axis limits.
`timescale 1ns / 100ps

module motion_command_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] left_horizontal,
  input  logic signed [15:0] left_vertical,
  input  logic signed [15:0] right_horizontal,
  input  logic signed [15:0] right_vertical,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] forward_velocity,
  input  logic signed [15:0] lateral_velocity,
  input  logic signed [15:0] yaw_rate,
  input  logic signed [15:0] body_pitch,
  input  logic signed [15:0] forward_step,
  input  logic signed [15:0] lateral_step,
  input  logic signed [15:0] yaw_step,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 pending,
  output int                 mismatches
);

  localparam int FieldCount = 7;
  localparam int ReportCap  = 200;

  // index 0 is forward_velocity, index 6 is yaw_step
  typedef logic [FieldCount-1:0][15:0] cmd_word_t;

  cmd_word_t expected_cmds[$];

  logic [15:0] gain_q;
  logic [14:0] band_q;
  logic [15:0] step_q;
  logic [15:0] fwd_span_q;
  logic [15:0] lat_span_q;
  logic [15:0] turn_span_q;
  logic [15:0] pitch_span_q;

  logic signed [15:0] lh_s;
  logic signed [15:0] lv_s;
  logic signed [15:0] rh_s;
  logic signed [15:0] rv_s;

  cmd_word_t want;
  cmd_word_t actual;
  int        bad;

  initial begin
    pending    = 0;
    mismatches = 0;
  end

  function automatic string field_name(input int i);
    case (i)
      0: return "forward_velocity";
      1: return "lateral_velocity";
      2: return "yaw_rate";
      3: return "body_pitch";
      4: return "forward_step";
      5: return "lateral_step";
      default: return "yaw_step";
    endcase
  endfunction

  function automatic logic signed [15:0] negate_clamped(input logic signed [15:0] x);
    return (x == jcc_pkg::AXIS_MIN) ? jcc_pkg::AXIS_MAX : -x;
  endfunction

  function automatic logic signed [15:0] smooth_axis(input logic signed [15:0] s,
                                                     input logic signed [15:0] x);
    longint g;
    longint acc;
    g   = gain_q;
    acc = longint'(s) * (64'sd65536 - g) + longint'(x) * g;
    return 16'(acc >>> 16);
  endfunction

  function automatic logic signed [15:0] band_axis(input logic signed [15:0] s,
                                                   input logic [15:0] span);
    longint d;
    longint v;
    longint p;
    d = band_q;
    v = s;
    p = span;
    // values on the band edge count as outside
    if (v < d && v > -d) return '0;
    return 16'((v * p) >>> 16);
  endfunction

  function automatic logic signed [15:0] scale_rate(input logic signed [15:0] rate);
    longint v;
    longint t;
    v = rate;
    t = step_q;
    return 16'((v * t) >>> 16);
  endfunction

  // advance the filter state and build the command set for one sample
  function automatic cmd_word_t condition_sample(input logic signed [15:0] lh,
                                                 input logic signed [15:0] lv,
                                                 input logic signed [15:0] rh,
                                                 input logic signed [15:0] rv);
    cmd_word_t c;
    lh_s = smooth_axis(lh_s, negate_clamped(lh));
    lv_s = smooth_axis(lv_s, lv);
    rh_s = smooth_axis(rh_s, negate_clamped(rh));
    rv_s = smooth_axis(rv_s, rv);
    c[0] = band_axis(lv_s, fwd_span_q);
    c[1] = band_axis(lh_s, lat_span_q);
    c[2] = band_axis(rh_s, turn_span_q);
    c[3] = band_axis(rv_s, pitch_span_q);
    c[4] = scale_rate(c[0]);
    c[5] = scale_rate(c[1]);
    c[6] = scale_rate(c[2]);
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gain_q       = jcc_pkg::RST_FILTER_GAIN;
      band_q       = jcc_pkg::RST_DEADBAND_WIDTH;
      step_q       = jcc_pkg::RST_STEP_TIME;
      fwd_span_q   = jcc_pkg::RST_SPAN;
      lat_span_q   = jcc_pkg::RST_SPAN;
      turn_span_q  = jcc_pkg::RST_SPAN;
      pitch_span_q = jcc_pkg::RST_SPAN;
      lh_s = '0;
      lv_s = '0;
      rh_s = '0;
      rv_s = '0;
      expected_cmds.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          jcc_pkg::REG_FILTER_GAIN:    gain_q       = cfg_data;
          jcc_pkg::REG_DEADBAND_WIDTH: band_q       = cfg_data[14:0];
          jcc_pkg::REG_STEP_TIME:      step_q       = cfg_data;
          jcc_pkg::REG_FORWARD_SPAN:   fwd_span_q   = cfg_data;
          jcc_pkg::REG_LATERAL_SPAN:   lat_span_q   = cfg_data;
          jcc_pkg::REG_TURN_SPAN:      turn_span_q  = cfg_data;
          jcc_pkg::REG_PITCH_SPAN:     pitch_span_q = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall)
        expected_cmds.push_back(condition_sample(left_horizontal, left_vertical,
                                                 right_horizontal, right_vertical));

      if (out_valid && !out_stall) begin
        bad = 0;
        if (expected_cmds.size() == 0) begin
          bad = 1;
          if (mismatches < ReportCap)
            $error("command set transferred with none expected");
        end else begin
          want   = expected_cmds.pop_front();
          actual = {yaw_step, lateral_step, forward_step, body_pitch,
                    yaw_rate, lateral_velocity, forward_velocity};
          for (int i = 0; i < FieldCount; i++) begin
            if (actual[i] !== want[i]) begin
              if (mismatches + bad < ReportCap)
                $error("%s: expected %0d, actual %0d", field_name(i),
                       $signed(want[i]), $signed(actual[i]));
              bad++;
            end
          end
        end
        mismatches <= mismatches + bad;
      end

      pending <= expected_cmds.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the joystick command conditioner testbench: clock, reset, samples,
// register writes and random stalls; the verdict comes from the checker.
// Depends on jcc_pkg, joystick_command_conditioner and motion_command_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CycleLimit   = 400000;
  localparam int PhaseCount   = 12;
  localparam int PhaseSamples = 95;
  localparam int SettleCycles = 20;
  localparam int MaxGap       = 13;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] left_horizontal = '0;
  logic signed [15:0] left_vertical = '0;
  logic signed [15:0] right_horizontal = '0;
  logic signed [15:0] right_vertical = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] forward_velocity;
  logic signed [15:0] lateral_velocity;
  logic signed [15:0] yaw_rate;
  logic signed [15:0] body_pitch;
  logic signed [15:0] forward_step;
  logic signed [15:0] lateral_step;
  logic signed [15:0] yaw_step;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  int pending;
  int mismatches;
  int cycle_count = 0;
  bit calm = 1'b0;

  joystick_command_conditioner dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .left_horizontal  (left_horizontal),
    .left_vertical    (left_vertical),
    .right_horizontal (right_horizontal),
    .right_vertical   (right_vertical),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .forward_velocity (forward_velocity),
    .lateral_velocity (lateral_velocity),
    .yaw_rate         (yaw_rate),
    .body_pitch       (body_pitch),
    .forward_step     (forward_step),
    .lateral_step     (lateral_step),
    .yaw_step         (yaw_step),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  motion_command_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .left_horizontal  (left_horizontal),
    .left_vertical    (left_vertical),
    .right_horizontal (right_horizontal),
    .right_vertical   (right_vertical),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .forward_velocity (forward_velocity),
    .lateral_velocity (lateral_velocity),
    .yaw_rate         (yaw_rate),
    .body_pitch       (body_pitch),
    .forward_step     (forward_step),
    .lateral_step     (lateral_step),
    .yaw_step         (yaw_step),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pending          (pending),
    .mismatches       (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // leaves cfg_valid high so back-to-back writes need no extra step
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [15:0] gain, input logic [15:0] band,
                                input logic [15:0] stp, input logic [15:0] fs,
                                input logic [15:0] ls, input logic [15:0] ts,
                                input logic [15:0] ps);
    write_reg(jcc_pkg::REG_FILTER_GAIN, gain);
    write_reg(jcc_pkg::REG_DEADBAND_WIDTH, band);
    write_reg(jcc_pkg::REG_STEP_TIME, stp);
    write_reg(jcc_pkg::REG_FORWARD_SPAN, fs);
    write_reg(jcc_pkg::REG_LATERAL_SPAN, ls);
    write_reg(jcc_pkg::REG_TURN_SPAN, ts);
    write_reg(jcc_pkg::REG_PITCH_SPAN, ps);
    // must be dropped by the block
    write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [15:0] lh, input logic [15:0] lv,
                             input logic [15:0] rh, input logic [15:0] rv);
    int gap;
    in_valid         <= 1'b1;
    left_horizontal  <= lh;
    left_vertical    <= lv;
    right_horizontal <= rh;
    right_vertical   <= rv;
    do @(posedge clk); while (in_stall);
    gap = calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, then hold until every expected command set has been transferred
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] draw_axis();
    case ($urandom_range(0, 7))
      0: return jcc_pkg::AXIS_MIN;
      1: return jcc_pkg::AXIS_MAX;
      2: return 16'($urandom_range(0, 4000)) - 16'd2000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] draw_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] draw_band();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom_range(0, 6000)) | (16'($urandom_range(0, 1)) << 15);
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // half gain from zero state: an input of twice the band lands on the edge;
    // top bit of the band write is dropped
    apply_settings(16'd32768, 16'h83e8, 16'hffff, 16'hffff, 16'd1, 16'd0, 16'd32768);
    send_sample(-16'sd2000, -16'sd2000, 16'sd1998, 16'sd1998);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    repeat (3) send_sample(jcc_pkg::AXIS_MIN, jcc_pkg::AXIS_MIN,
                           jcc_pkg::AXIS_MIN, jcc_pkg::AXIS_MIN);
    repeat (3) send_sample(jcc_pkg::AXIS_MAX, jcc_pkg::AXIS_MAX,
                           jcc_pkg::AXIS_MAX, jcc_pkg::AXIS_MAX);
    repeat (2) send_sample(jcc_pkg::AXIS_MIN, jcc_pkg::AXIS_MAX,
                           jcc_pkg::AXIS_MIN, jcc_pkg::AXIS_MAX);
    repeat (2) send_sample(jcc_pkg::AXIS_MAX, jcc_pkg::AXIS_MIN,
                           jcc_pkg::AXIS_MAX, jcc_pkg::AXIS_MIN);
    drain();

    // zero gain holds the filter; zero band forces nothing to zero
    apply_settings(16'd0, 16'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_sample(jcc_pkg::AXIS_MIN, jcc_pkg::AXIS_MAX, jcc_pkg::AXIS_MAX, jcc_pkg::AXIS_MIN);
    send_sample(16'h0001, 16'hffff, 16'h1234, 16'hedcb);
    send_sample(jcc_pkg::AXIS_MAX, jcc_pkg::AXIS_MIN, jcc_pkg::AXIS_MIN, jcc_pkg::AXIS_MAX);
    drain();

    // full gain and widest band: only smoothed values of -32767 and below get out
    apply_settings(16'hffff, 16'h7fff, 16'd0, 16'd256, 16'd256, 16'd256, 16'd256);
    repeat (3) send_sample(jcc_pkg::AXIS_MAX, jcc_pkg::AXIS_MIN,
                           jcc_pkg::AXIS_MAX, jcc_pkg::AXIS_MIN);
    repeat (3) send_sample(jcc_pkg::AXIS_MIN, jcc_pkg::AXIS_MAX,
                           jcc_pkg::AXIS_MIN, jcc_pkg::AXIS_MAX);
    drain();

    for (int p = 0; p < PhaseCount; p++) begin
      calm = (p % 4 == 3);
      case (p)
        0: apply_settings(jcc_pkg::RST_FILTER_GAIN, 16'(jcc_pkg::RST_DEADBAND_WIDTH),
                          jcc_pkg::RST_STEP_TIME, jcc_pkg::RST_SPAN, jcc_pkg::RST_SPAN,
                          jcc_pkg::RST_SPAN, jcc_pkg::RST_SPAN);
        1: apply_settings(16'hffff, 16'h7fff, 16'hffff, 16'hffff, 16'hffff,
                          16'hffff, 16'hffff);
        2: apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 16'h0000);
        default: apply_settings(draw_word(), draw_band(), draw_word(), draw_word(),
                                draw_word(), draw_word(), draw_word());
      endcase
      repeat (PhaseSamples) send_sample(draw_axis(), draw_axis(), draw_axis(), draw_axis());
      drain();
    end

    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // result side: stall for a drawn number of cycles, then wait for the transfer
  initial begin
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, MaxGap);
      out_stall <= (hold > 0);
      if (hold > 0) begin
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

endmodule
